// ===== sv/dvdd_pkg.sv =====
package dvdd_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int SERIAL_W = 22;
  localparam int DIFF_W   = 23;
  localparam int CFG_W    = 14;
  localparam int MDAY_W   = 10;

  // Quotient by 100 as a reciprocal multiply: exact for every 14-bit year up to 9999
  localparam int              RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int              RECIP_SHIFT = 19;
  localparam int              PROD_W      = YEAR_W + RECIP_W;
  localparam int              Q_W         = PROD_W - RECIP_SHIFT;

  localparam logic [YEAR_W-1:0]   YEAR_CAP     = 14'd9999;
  localparam logic [YEAR_W-1:0]   LOW_YEAR_RST = 14'd1;
  localparam logic [YEAR_W-1:0]   CUR_YEAR_RST = 14'd2023;
  localparam logic [SERIAL_W-1:0] EPOCH_OFS    = 22'd306;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_YEAR  = 2'd1,
    ST_BAD_MONTH = 2'd2,
    ST_BAD_DAY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_EARLIER = 2'd1,
    ORD_LATER   = 2'd2
  } order_t;

  typedef enum logic {
    CFG_LOW_YEAR     = 1'b0,
    CFG_CURRENT_YEAR = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // Days before the month in a March-based year: floor((153*tm - 457) / 5)
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] ofs;
    case (m)
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/dvdd_date_pipe.sv =====
module dvdd_date_pipe
  import dvdd_pkg::*;
(
  input  logic                clk,
  input  stage_en_t           en,
  input  logic [YEAR_W-1:0]   low_year,
  input  logic [YEAR_W-1:0]   current_year,
  input  logic [YEAR_W-1:0]   year,
  input  logic [MONTH_W-1:0]  month,
  input  logic [DAY_W-1:0]    day,
  output status_t             status,
  output logic [SERIAL_W-1:0] serial
);

  // stage 1: range checks, March-based year, quotients by 100
  logic [YEAR_W-1:0] lo, hi, ty;
  logic [YEAR_W:0]   hi_ext;
  logic              yr_ok, mo_ok;
  logic [PROD_W-1:0] prod_y, prod_ty;

  logic [YEAR_W-1:0]  y_r, ty_r;
  logic [MONTH_W-1:0] m_r;
  logic [DAY_W-1:0]   d_r;
  logic               yr_ok_r, mo_ok_r;
  logic [Q_W-1:0]     q_y_r, q_ty_r;

  always_comb begin
    lo     = (low_year == '0) ? YEAR_W'(1) : low_year;
    hi_ext = {1'b0, current_year} + (YEAR_W+1)'(1);
    hi     = (hi_ext > {1'b0, YEAR_CAP}) ? YEAR_CAP : hi_ext[YEAR_W-1:0];
    yr_ok  = (year >= lo) && (year <= hi);
    mo_ok  = month inside {[4'd1:4'd12]};
    ty     = (month < 4'd3) ? year - YEAR_W'(1) : year;
    prod_y  = PROD_W'(year) * PROD_W'(RECIP_100);
    prod_ty = PROD_W'(ty) * PROD_W'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y_r     <= year;
      ty_r    <= ty;
      m_r     <= month;
      d_r     <= day;
      yr_ok_r <= yr_ok;
      mo_ok_r <= mo_ok;
      q_y_r   <= prod_y[PROD_W-1:RECIP_SHIFT];
      q_ty_r  <= prod_ty[PROD_W-1:RECIP_SHIFT];
    end
  end

  // stage 2: leap test, day check, status, year and month-day parts of the day number
  logic [YEAR_W-1:0]   rem100;
  logic                leap, d_ok;
  logic [DAY_W-1:0]    len;
  status_t             st2;
  logic [SERIAL_W-1:0] part;

  status_t             st2_r;
  logic [SERIAL_W-1:0] part_r;
  logic [MDAY_W-1:0]   mday_r;

  always_comb begin
    rem100 = y_r - YEAR_W'(YEAR_W'(q_y_r) * YEAR_W'(100));
    leap   = (y_r[1:0] == 2'b00) && ((rem100 != '0) || (q_y_r[1:0] == 2'b00));
    len    = month_days(m_r, leap);
    d_ok   = (d_r != '0) && (d_r <= len);
    if (!yr_ok_r)      st2 = ST_BAD_YEAR;
    else if (!mo_ok_r) st2 = ST_BAD_MONTH;
    else if (!d_ok)    st2 = ST_BAD_DAY;
    else               st2 = ST_OK;
    part = SERIAL_W'(ty_r) * SERIAL_W'(365) + SERIAL_W'(ty_r >> 2)
           - SERIAL_W'(q_ty_r) + SERIAL_W'(q_ty_r >> 2);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      st2_r  <= st2;
      part_r <= part;
      mday_r <= MDAY_W'(month_offset(m_r)) + MDAY_W'(d_r);
    end
  end

  // stage 3: final day number, zero for an invalid date
  status_t             st3_r;
  logic [SERIAL_W-1:0] serial_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      st3_r    <= st2_r;
      serial_r <= (st2_r == ST_OK) ? part_r + SERIAL_W'(mday_r) - EPOCH_OFS : '0;
    end
  end

  assign status = st3_r;
  assign serial = serial_r;

endmodule

// ===== sv/dvdd_compare.sv =====
module dvdd_compare
  import dvdd_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  status_t                   status_a,
  input  status_t                   status_b,
  input  logic [SERIAL_W-1:0]       serial_a,
  input  logic [SERIAL_W-1:0]       serial_b,
  output status_t                   status_a_o,
  output status_t                   status_b_o,
  output logic [SERIAL_W-1:0]       serial_a_o,
  output logic [SERIAL_W-1:0]       serial_b_o,
  output logic signed [DIFF_W-1:0]  day_difference,
  output order_t                    order
);

  status_t                  st_a_r, st_b_r;
  logic [SERIAL_W-1:0]      ser_a_r, ser_b_r;
  logic signed [DIFF_W-1:0] diff_r;
  order_t                   ord_r;
  order_t                   ord;

  always_comb begin
    if (serial_a == serial_b)     ord = ORD_EQUAL;
    else if (serial_a < serial_b) ord = ORD_EARLIER;
    else                          ord = ORD_LATER;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_a_r  <= status_a;
      st_b_r  <= status_b;
      ser_a_r <= serial_a;
      ser_b_r <= serial_b;
      diff_r  <= $signed({1'b0, serial_a} - {1'b0, serial_b});
      ord_r   <= ord;
    end
  end

  assign status_a_o     = st_a_r;
  assign status_b_o     = st_b_r;
  assign serial_a_o     = ser_a_r;
  assign serial_b_o     = ser_b_r;
  assign day_difference = diff_r;
  assign order          = ord_r;

endmodule

// ===== sv/date_validate_and_day_difference.sv =====
// Throughput: one item per cycle while the output is not stalled; four register
// stages, each advancing when the stage after it is empty or moving.
// Reset (synchronous, rst_n low): pipeline empties, the lowest valid year
// returns to 1 and current_year to 2023.
module date_validate_and_day_difference
  import dvdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
  // day_b[45:41], zero [47:46]
  input  logic [47:0]       in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // status_a[1:0], status_b[3:2], serial_a[25:4], serial_b[47:26],
  // day_difference[70:48], order[72:71], zero [79:73]
  output logic [79:0]       out_tdata,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic [YEAR_W-1:0] low_year_r, cur_year_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_year_r <= LOW_YEAR_RST;
      cur_year_r <= CUR_YEAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW_YEAR:     low_year_r <= cfg_wdata;
        CFG_CURRENT_YEAR: cur_year_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // stage valid bits and the ready chain
  logic      v1_r, v2_r, v3_r, v4_r;
  logic      rdy1, rdy2, rdy3, rdy4;
  stage_en_t en;

  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign en.s1 = in_tvalid && rdy1;
  assign en.s2 = v1_r && rdy2;
  assign en.s3 = v2_r && rdy3;
  assign en.s4 = v3_r && rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign in_tready  = rdy1;
  assign out_tvalid = v4_r;

  status_t             st_a, st_b;
  logic [SERIAL_W-1:0] ser_a, ser_b;

  dvdd_date_pipe u_pipe_a (
    .clk          (clk),
    .en           (en),
    .low_year     (low_year_r),
    .current_year (cur_year_r),
    .year         (in_tdata[13:0]),
    .month        (in_tdata[17:14]),
    .day          (in_tdata[22:18]),
    .status       (st_a),
    .serial       (ser_a)
  );

  dvdd_date_pipe u_pipe_b (
    .clk          (clk),
    .en           (en),
    .low_year     (low_year_r),
    .current_year (cur_year_r),
    .year         (in_tdata[36:23]),
    .month        (in_tdata[40:37]),
    .day          (in_tdata[45:41]),
    .status       (st_b),
    .serial       (ser_b)
  );

  status_t                  o_st_a, o_st_b;
  logic [SERIAL_W-1:0]      o_ser_a, o_ser_b;
  logic signed [DIFF_W-1:0] o_diff;
  order_t                   o_ord;

  dvdd_compare u_cmp (
    .clk            (clk),
    .en             (en.s4),
    .status_a       (st_a),
    .status_b       (st_b),
    .serial_a       (ser_a),
    .serial_b       (ser_b),
    .status_a_o     (o_st_a),
    .status_b_o     (o_st_b),
    .serial_a_o     (o_ser_a),
    .serial_b_o     (o_ser_b),
    .day_difference (o_diff),
    .order          (o_ord)
  );

  assign out_tdata = {7'b0, o_ord, o_diff, o_ser_b, o_ser_a, o_st_b, o_st_a};

  // an invalid first date never carries a day number
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (o_st_a != ST_OK) |-> (o_ser_a == '0))
    else $error("invalid first date with nonzero day number");

  // ordering agrees with the sign of the difference
  a_order_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((o_ord == ORD_EQUAL) == (o_diff == '0)) &&
                   ((o_ord == ORD_EARLIER) == o_diff[DIFF_W-1]))
    else $error("order code disagrees with day difference");

  // input stalls only behind a held first stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v1_r && v2_r && v3_r && v4_r && !out_tready)
    else $error("input stalled with room in the pipeline");

  // a held third stage keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !rdy4 |=> v3_r)
    else $error("item lost in stage three");

endmodule
